FILE: rtl/swf_pkg.sv
// swf_pkg: shared types, constants and character helpers for the stop word filter
// no dependencies
package swf_pkg;

   typedef enum logic [2:0] {
      CMD_CLEAR    = 3'd0,
      CMD_STOP     = 3'd1,
      CMD_STOP_END = 3'd2,
      CMD_TEXT     = 3'd3,
      CMD_TEXT_END = 3'd4
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRIM_END,
      ST_TRIM_START,
      ST_STORE,
      ST_SEARCH,
      ST_SEARCH_WAIT,
      ST_SEARCH_NEXT,
      ST_EMIT_CHAR,
      ST_EMIT_SPACE,
      ST_EMIT_NL,
      ST_REPORT
   } state_type;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] LIMIT_RESET  = 8'd30;
   localparam logic       KIND_TEXT    = 1'b0;
   localparam logic       KIND_REPORT  = 1'b1;

   function automatic logic is_space(input logic [7:0] c);
      is_space = (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_alnum(input logic [7:0] c);
      is_alnum = ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h7A))
              || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

endpackage

FILE: rtl/stop_word_filter_core.sv
// stop_word_filter_core: splits a byte stream into words, drops stop words,
// and re-emits the remaining words with line wrapping; uses swf_pkg
//
// User notes: one item is taken at a time. A byte that extends a word is taken
// without leaving idle, so such items can follow back to back. Closing a word
// trims it in two passes, first from its end, then from its start; a stop word
// is then written into the table one byte a cycle, then its length (nothing is
// written when the table is full). A text word is compared with every table
// entry through one shared byte comparator reading the stop memory: an entry
// whose length differs is skipped once its length is read, and an entry of equal
// length is compared byte by byte until a mismatch or its end. Unmatched words
// then stream out one byte per cycle while results are taken, and the line
// count is updated before the space. The next item waits until the last
// result has been taken. The stop table is a memory with a fill count, so no
// clearing pass is needed after reset.
// line_limit may be written only while idle.
module stop_word_filter_core #(
   parameter int MAX_WORD       = 32,
   parameter int MAX_STOP_WORDS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_kind,
   output logic [7:0]  rsp_char_out,
   output logic [31:0] rsp_stop_total,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_line_limit
);

   localparam int LW = $clog2(MAX_WORD);           // word index bits
   localparam int LN = $clog2(MAX_WORD + 1);       // word length bits
   localparam int EW = $clog2(MAX_STOP_WORDS);     // entry index bits (>=1 via max below)
   localparam int EI = (EW < 1) ? 1 : EW;
   localparam int EC = $clog2(MAX_STOP_WORDS + 1); // entry count bits
   localparam int AW = EI + LW;

   // word buffer in flops, read at signal-chosen indices -> kept small (MAX_WORD<=62)
   logic [7:0] wbuf_ff [MAX_WORD];
   logic [7:0] stop_mem [MAX_STOP_WORDS * (2 ** LW)];
   logic [LN-1:0] stop_len_mem [MAX_STOP_WORDS];

   swf_pkg::state_type state_ff, state_in;
   logic [LN-1:0] wlen_ff, wlen_in;
   logic [LN-1:0] start_ff, start_in;
   logic [LN-1:0] end_ff, end_in;
   logic [LN-1:0] idx_ff, idx_in;
   logic          open_ff, open_in;
   logic [EC-1:0] entries_ff, entries_in;
   logic [EC-1:0] ent_ff, ent_in;
   logic          hit_ff, hit_in;
   logic          eq_ff, eq_in;
   logic [31:0]   count_ff, count_in;
   logic [8:0]    line_ff, line_in;
   logic [7:0]    limit_ff;
   logic          report_ff, report_in;

   // output register
   logic       out_v_ff, out_v_in;
   logic       out_k_ff, out_k_in;
   logic [7:0] out_c_ff, out_c_in;
   logic       out_l_ff, out_l_in;

   // memory reads (registered)
   logic [7:0]    mem_q_ff;
   logic [LN-1:0] len_q_ff;
   logic [AW-1:0] rd_addr;
   logic [EI-1:0] rd_ent;
   logic          mem_we;
   logic [AW-1:0] wr_addr;
   logic [7:0]    wr_data;
   logic          len_we;

   logic       accept;
   logic [2:0] cmd;
   logic [7:0] lc_char;
   logic [LN-1:0] tlen;
   logic [LW-1:0] cur_idx;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == swf_pkg::ST_IDLE) && !out_v_ff;
   assign csr_ready = 1'b1;
   assign cmd       = req_command;
   assign lc_char   = ((req_char_in >= 8'h41) && (req_char_in <= 8'h5A))
                      ? (req_char_in + 8'h20) : req_char_in;
   assign tlen      = end_ff - start_ff;
   assign cur_idx   = LW'(start_ff + idx_ff);

   assign rsp_valid      = out_v_ff;
   assign rsp_kind       = out_k_ff;
   assign rsp_char_out   = out_c_ff;
   assign rsp_stop_total = count_ff;
   assign rsp_last       = out_l_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= swf_pkg::ST_IDLE;
         wlen_ff    <= '0;
         open_ff    <= 1'b0;
         entries_ff <= '0;
         count_ff   <= '0;
         line_ff    <= '0;
         limit_ff   <= swf_pkg::LIMIT_RESET;
         out_v_ff   <= 1'b0;
         report_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wlen_ff    <= wlen_in;
         open_ff    <= open_in;
         entries_ff <= entries_in;
         count_ff   <= count_in;
         line_ff    <= line_in;
         out_v_ff   <= out_v_in;
         report_ff  <= report_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_line_limit;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      start_ff <= start_in;
      end_ff   <= end_in;
      idx_ff   <= idx_in;
      ent_ff   <= ent_in;
      hit_ff   <= hit_in;
      eq_ff    <= eq_in;
      out_k_ff <= out_k_in;
      out_c_ff <= out_c_in;
      out_l_ff <= out_l_in;
      if (accept && ((cmd == swf_pkg::CMD_STOP) || (cmd == swf_pkg::CMD_TEXT))
          && !swf_pkg::is_space(req_char_in)
          && (wlen_ff < LN'(MAX_WORD - 1))) begin
         wbuf_ff[LW'(wlen_ff)] <= lc_char;
      end
   end

   // stop table memories
   always_ff @(posedge clock) begin
      if (mem_we) begin
         stop_mem[wr_addr] <= wr_data;
      end
      if (len_we) begin
         stop_len_mem[EI'(entries_ff)] <= tlen;
      end
      mem_q_ff <= stop_mem[rd_addr];
      len_q_ff <= stop_len_mem[rd_ent];
   end

   assign rd_ent  = EI'(ent_ff);
   assign rd_addr = {rd_ent, LW'(idx_ff)};
   assign wr_addr = {EI'(entries_ff), LW'(idx_ff)};
   assign wr_data = wbuf_ff[cur_idx];

   always_comb begin
      state_in   = state_ff;
      wlen_in    = wlen_ff;
      open_in    = open_ff;
      start_in   = start_ff;
      end_in     = end_ff;
      idx_in     = idx_ff;
      entries_in = entries_ff;
      ent_in     = ent_ff;
      hit_in     = hit_ff;
      eq_in      = eq_ff;
      count_in   = count_ff;
      line_in    = line_ff;
      report_in  = report_ff;
      out_v_in   = out_v_ff && !rsp_ready;
      out_k_in   = out_k_ff;
      out_c_in   = out_c_ff;
      out_l_in   = out_l_ff;
      mem_we     = 1'b0;
      len_we     = 1'b0;

      case (state_ff)
         swf_pkg::ST_IDLE: begin
            if (accept) begin
               report_in = 1'b0;
               case (cmd)
                  swf_pkg::CMD_CLEAR: begin
                     entries_in = '0;
                     count_in   = '0;
                     line_in    = '0;
                     open_in    = 1'b0;
                     wlen_in    = '0;
                  end
                  swf_pkg::CMD_STOP, swf_pkg::CMD_TEXT: begin
                     if (swf_pkg::is_space(req_char_in)) begin
                        if (open_ff) begin
                           hit_in   = (cmd == swf_pkg::CMD_STOP);
                           end_in   = wlen_ff;
                           state_in = swf_pkg::ST_TRIM_END;
                        end
                     end else begin
                        open_in = 1'b1;
                        if (wlen_ff < LN'(MAX_WORD - 1)) begin
                           wlen_in = wlen_ff + 1'b1;
                        end
                     end
                  end
                  swf_pkg::CMD_STOP_END: begin
                     if (open_ff) begin
                        hit_in   = 1'b1;
                        end_in   = wlen_ff;
                        state_in = swf_pkg::ST_TRIM_END;
                     end
                  end
                  swf_pkg::CMD_TEXT_END: begin
                     report_in = 1'b1;
                     if (open_ff) begin
                        hit_in   = 1'b0;
                        end_in   = wlen_ff;
                        state_in = swf_pkg::ST_TRIM_END;
                     end else begin
                        state_in = swf_pkg::ST_REPORT;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // hit_ff flags a stop word during trimming
         swf_pkg::ST_TRIM_END: begin
            if ((end_ff != '0) && !swf_pkg::is_alnum(wbuf_ff[LW'(end_ff - 1'b1)])) begin
               end_in = end_ff - 1'b1;
            end else begin
               start_in = '0;
               state_in = swf_pkg::ST_TRIM_START;
            end
         end
         swf_pkg::ST_TRIM_START: begin
            if ((start_ff < end_ff) && !swf_pkg::is_alnum(wbuf_ff[LW'(start_ff)])) begin
               start_in = start_ff + 1'b1;
            end else begin
               idx_in = '0;
               ent_in = '0;
               wlen_in = '0;
               open_in = 1'b0;
               if (hit_ff) begin
                  state_in = swf_pkg::ST_STORE;
               end else begin
                  hit_in   = 1'b0;
                  state_in = swf_pkg::ST_SEARCH;
               end
            end
         end
         swf_pkg::ST_STORE: begin
            if (entries_ff >= EC'(MAX_STOP_WORDS)) begin
               state_in = swf_pkg::ST_IDLE;
            end else if (idx_ff < tlen) begin
               mem_we = 1'b1;
               idx_in = idx_ff + 1'b1;
            end else begin
               len_we     = 1'b1;
               entries_in = entries_ff + 1'b1;
               state_in   = swf_pkg::ST_IDLE;
            end
         end
         // one entry: issue length read and first byte, then compare byte by byte
         swf_pkg::ST_SEARCH: begin
            if (ent_ff >= entries_ff) begin
               idx_in = '0;
               if (hit_ff) begin
                  state_in = report_ff ? swf_pkg::ST_REPORT : swf_pkg::ST_IDLE;
               end else begin
                  state_in = swf_pkg::ST_EMIT_CHAR;
               end
            end else begin
               idx_in   = '0;
               eq_in    = 1'b1;
               state_in = swf_pkg::ST_SEARCH_WAIT;
            end
         end
         swf_pkg::ST_SEARCH_WAIT: begin
            // read of byte idx issued here; its data is seen in ST_SEARCH_NEXT
            idx_in   = idx_ff + 1'b1;
            state_in = swf_pkg::ST_SEARCH_NEXT;
         end
         swf_pkg::ST_SEARCH_NEXT: begin
            // mem_q_ff holds byte idx_ff-1
            if ((len_q_ff != tlen) || !eq_ff) begin
               ent_in   = ent_ff + 1'b1;
               state_in = swf_pkg::ST_SEARCH;
            end else if (idx_ff > tlen) begin
               hit_in = 1'b1;
               if (count_ff != 32'hFFFF_FFFF) begin
                  count_in = count_ff + 1'b1;
               end
               ent_in   = ent_ff + 1'b1;
               state_in = swf_pkg::ST_SEARCH;
            end else begin
               if (mem_q_ff != wbuf_ff[LW'(start_ff + idx_ff - 1'b1)]) begin
                  eq_in = 1'b0;
               end
               idx_in = idx_ff + 1'b1;
            end
         end
         swf_pkg::ST_EMIT_CHAR: begin
            if (!out_v_ff || rsp_ready) begin
               if (idx_ff < tlen) begin
                  out_v_in = 1'b1;
                  out_k_in = swf_pkg::KIND_TEXT;
                  out_c_in = wbuf_ff[cur_idx];
                  out_l_in = 1'b0;
                  idx_in   = idx_ff + 1'b1;
               end else begin
                  line_in  = line_ff + 9'(tlen);
                  state_in = swf_pkg::ST_EMIT_SPACE;
               end
            end
         end
         swf_pkg::ST_EMIT_SPACE: begin
            if (!out_v_ff || rsp_ready) begin
               out_v_in = 1'b1;
               out_k_in = swf_pkg::KIND_TEXT;
               out_c_in = swf_pkg::CHAR_SPACE;
               if (line_ff > {1'b0, limit_ff}) begin
                  out_l_in = 1'b0;
                  state_in = swf_pkg::ST_EMIT_NL;
               end else begin
                  out_l_in = !report_ff;
                  state_in = report_ff ? swf_pkg::ST_REPORT : swf_pkg::ST_IDLE;
               end
            end
         end
         swf_pkg::ST_EMIT_NL: begin
            if (!out_v_ff || rsp_ready) begin
               out_v_in = 1'b1;
               out_k_in = swf_pkg::KIND_TEXT;
               out_c_in = swf_pkg::CHAR_NEWLINE;
               out_l_in = !report_ff;
               line_in  = '0;
               state_in = report_ff ? swf_pkg::ST_REPORT : swf_pkg::ST_IDLE;
            end
         end
         swf_pkg::ST_REPORT: begin
            if (!out_v_ff || rsp_ready) begin
               out_v_in = 1'b1;
               out_k_in = swf_pkg::KIND_REPORT;
               out_c_in = 8'h00;
               out_l_in = 1'b1;
               state_in = swf_pkg::ST_IDLE;
            end
         end
         default: state_in = swf_pkg::ST_IDLE;
      endcase
   end

   // stop table never overfills
   assert property (@(posedge clock) disable iff (reset) entries_ff <= EC'(MAX_STOP_WORDS))
      else $error("stop table count overflow");
   // no new item taken while a result is pending
   assert property (@(posedge clock) disable iff (reset) rsp_valid |-> !req_ready)
      else $error("item accepted with result pending");
   // trimmed word bounds stay ordered during the search
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == swf_pkg::ST_SEARCH) |-> (start_ff <= end_ff))
      else $error("trim bounds crossed");

endmodule
